[rtl/bezier_tension_tessellator_assert.svh]
// Assertion macros for the checker file of the tessellator.
`ifndef BEZIER_TENSION_TESSELLATOR_ASSERT_SVH
`define BEZIER_TENSION_TESSELLATOR_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define BTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/btt_pkg.sv]
`timescale 1ns / 1ps

package btt_pkg;

    // Sizes of the configuration and of the payload.
    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 32;
    localparam int LEVEL_W    = 3;
    localparam int TENSION_W  = 17;
    localparam int MAXP_W     = 7;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Internal arithmetic widths.
    localparam int DD_W   = 6;
    localparam int SQ_W   = 12;
    localparam int D3_W   = 18;
    localparam int WGT_W  = 20;
    localparam int ACC_W  = 52;
    localparam int SUM_W  = 33;
    localparam int BLD_SHIFT = 17;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_ITERS  = ACC_W / DIV_STEPS;
    localparam int DIV_CNT_W  = 4;
    localparam int REM_W      = D3_W + 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TENSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd2;

    localparam logic [LEVEL_W-1:0]   LEVEL_MIN    = 3'd1;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 3'd6;
    localparam logic [TENSION_W-1:0] TENSION_ONE  = 17'd65536;
    localparam logic [TENSION_W-1:0] TENSION_HALF = 17'd32768;
    localparam logic [MAXP_W-1:0]    MAXP_CAP     = MAXP_W'(MAX_POINTS);

    localparam logic signed [ACC_W-1:0] BLD_ROUND = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO    = -ACC_W'(64'sd2147483648);

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p0_z;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p1_z;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p2_z;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic signed [COORD_W-1:0] p3_z;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      last_point;
    } out_item_t;

    // One classified item as it waits for the back end.
    typedef struct packed {
        in_item_t             pts;
        logic [TENSION_W-1:0] tension;
        logic [MAXP_W-1:0]    n;
        logic [DD_W-1:0]      dd;
        logic [D3_W-1:0]      d3;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_CUBE,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQUARE,
        B_WEIGHT,
        B_MAC,
        B_DIVGO,
        B_DIVWAIT,
        B_BLEND,
        B_ROUND,
        B_PUT
    } back_state_t;

endpackage

[rtl/btt_if.sv]
`timescale 1ns / 1ps

// Control point channel.
interface btt_in_if;
    logic                valid;
    logic                ready;
    btt_pkg::in_item_t   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// Curve point channel.
interface btt_out_if;
    logic                valid;
    logic                ready;
    btt_pkg::out_item_t  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// Register write channel.
interface btt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [btt_pkg::CFG_IDX_W-1:0]     index;
    logic [btt_pkg::CFG_DATA_W-1:0]    wdata;
    modport source(output valid, output index, output wdata, input ready);
    modport sink(input valid, input index, input wdata, output ready);
endinterface

[rtl/btt_front.sv]
`timescale 1ns / 1ps

module btt_front
(
    input  logic                clk,
    input  logic                rst_n,
    btt_in_if.sink              items,
    btt_cfg_if.sink             cfg,
    input  btt_pkg::q_stat_t    qstat,
    output logic                push,
    output btt_pkg::job_t       push_job
);

    btt_pkg::front_state_t state_reg, state_next;

    logic [btt_pkg::LEVEL_W-1:0]   level_reg;
    logic [btt_pkg::TENSION_W-1:0] tension_reg;
    logic [btt_pkg::MAXP_W-1:0]    max_reg;

    btt_pkg::job_t                 job_reg;
    logic [btt_pkg::SQ_W-1:0]      dd2_reg;

    logic [btt_pkg::MAXP_W-1:0]    pow_n;
    logic [btt_pkg::MAXP_W-1:0]    n_cap;
    logic [btt_pkg::MAXP_W-1:0]    n_pts;
    logic [btt_pkg::DD_W-1:0]      dd_val;
    logic [btt_pkg::LEVEL_W-1:0]   lvl_w;
    logic [btt_pkg::TENSION_W-1:0] ten_w;
    logic                          accept;

    // Registers are always writable.
    assign cfg.ready = 1'b1;

    // Clamp the level; a tension above one falls back to one half.
    always_comb
    begin
        lvl_w = cfg.wdata[btt_pkg::LEVEL_W-1:0];
        if (lvl_w < btt_pkg::LEVEL_MIN)
        begin
            lvl_w = btt_pkg::LEVEL_MIN;
        end
        if (lvl_w > btt_pkg::LEVEL_MAX)
        begin
            lvl_w = btt_pkg::LEVEL_MAX;
        end
        ten_w = cfg.wdata;
        if (ten_w > btt_pkg::TENSION_ONE)
        begin
            ten_w = btt_pkg::TENSION_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= btt_pkg::LEVEL_MIN;
            tension_reg <= btt_pkg::TENSION_HALF;
            max_reg     <= btt_pkg::MAXP_CAP;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                btt_pkg::REG_LEVEL:   level_reg   <= lvl_w;
                btt_pkg::REG_TENSION: tension_reg <= ten_w;
                btt_pkg::REG_MAX:     max_reg     <= cfg.wdata[btt_pkg::MAXP_W-1:0];
                default:              ;
            endcase
        end
    end

    // Point count of the next item and the span D between its end points.
    always_comb
    begin
        pow_n = btt_pkg::MAXP_W'(1) << level_reg;
        n_cap = (pow_n < max_reg) ? pow_n : max_reg;
        n_pts = (n_cap < btt_pkg::MAXP_CAP) ? n_cap : btt_pkg::MAXP_CAP;
        dd_val = (n_pts > btt_pkg::MAXP_W'(1)) ?
                 btt_pkg::DD_W'(n_pts - btt_pkg::MAXP_W'(1)) : btt_pkg::DD_W'(1);
    end

    assign accept = items.valid && items.ready;

    // Next state and handshake outputs.
    always_comb
    begin
        state_next  = state_reg;
        items.ready = 1'b0;
        push        = 1'b0;
        case (state_reg)
            btt_pkg::F_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid && n_pts != '0)
                begin
                    state_next = btt_pkg::F_SQUARE;
                end
            end
            btt_pkg::F_SQUARE: state_next = btt_pkg::F_CUBE;
            btt_pkg::F_CUBE:   state_next = btt_pkg::F_PUSH;
            btt_pkg::F_PUSH:
            begin
                if (!qstat.full)
                begin
                    push       = 1'b1;
                    state_next = btt_pkg::F_IDLE;
                end
            end
            default: state_next = btt_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btt_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the item, then work out D^3 over two multiply steps.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.pts     <= items.data;
            job_reg.tension <= tension_reg;
            job_reg.n       <= n_pts;
            job_reg.dd      <= dd_val;
        end
        if (state_reg == btt_pkg::F_SQUARE)
        begin
            dd2_reg <= btt_pkg::SQ_W'(job_reg.dd) * btt_pkg::SQ_W'(job_reg.dd);
        end
        if (state_reg == btt_pkg::F_CUBE)
        begin
            job_reg.d3 <= btt_pkg::D3_W'(dd2_reg) * btt_pkg::D3_W'(job_reg.dd);
        end
    end

    assign push_job = job_reg;

endmodule

[rtl/btt_queue.sv]
`timescale 1ns / 1ps

module btt_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  btt_pkg::job_t       push_job,
    input  logic                pop,
    output btt_pkg::job_t       head,
    output btt_pkg::q_stat_t    qstat
);

    btt_pkg::job_t mem [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign head        = mem[rd_ptr_reg];

    // Two-entry job queue between the front and back ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/btt_div.sv]
`timescale 1ns / 1ps

module btt_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [btt_pkg::ACC_W-1:0]    num,
    input  logic [btt_pkg::D3_W-1:0]            den,
    output logic                                done,
    output logic signed [btt_pkg::COORD_W-1:0]  quo
);

    logic [btt_pkg::ACC_W-1:0]     mag_reg, mag_next;
    logic [btt_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [btt_pkg::D3_W-1:0]      den_reg;
    logic                          neg_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic [btt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [btt_pkg::ACC_W-1:0]     q_adj;

    // Several restoring steps per cycle; the remainder stays below the divisor.
    always_comb
    begin
        rem_next = rem_reg;
        mag_next = mag_reg;
        for (int j = 0; j < btt_pkg::DIV_STEPS; j++)
        begin
            rem_next = {rem_next[btt_pkg::REM_W-2:0], mag_next[btt_pkg::ACC_W-1]};
            mag_next = {mag_next[btt_pkg::ACC_W-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next    = rem_next - {1'b0, den_reg};
                mag_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == btt_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= btt_pkg::DIV_CNT_W'(btt_pkg::DIV_ITERS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - btt_pkg::DIV_CNT_W'(1);
                if (cnt_reg == btt_pkg::DIV_CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[btt_pkg::ACC_W-1];
            mag_reg <= num[btt_pkg::ACC_W-1] ? btt_pkg::ACC_W'(-num) : btt_pkg::ACC_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    // Floor division: a negative dividend with a remainder rounds one further down.
    assign q_adj = mag_reg + btt_pkg::ACC_W'(rem_reg != '0);
    assign quo   = neg_reg ? btt_pkg::COORD_W'(-q_adj) : btt_pkg::COORD_W'(mag_reg);
    assign done  = done_reg;

endmodule

[rtl/btt_back.sv]
`timescale 1ns / 1ps

module btt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  btt_pkg::q_stat_t    qstat,
    input  btt_pkg::job_t       head,
    output logic                pop,
    btt_out_if.source           points
);

    btt_pkg::back_state_t state_reg, state_next;

    btt_pkg::job_t                       job_reg;
    logic [btt_pkg::IDX_W-1:0]           i_reg;
    logic [btt_pkg::SQ_W-1:0]            a2_reg, b2_reg, ab_reg;
    logic [btt_pkg::WGT_W-1:0]           w_reg [0:3];
    logic [1:0]                          k_reg;
    logic signed [btt_pkg::ACC_W-1:0]    acc_reg [0:2];
    logic signed [btt_pkg::ACC_W-1:0]    prod1_reg [0:2];
    logic signed [btt_pkg::ACC_W-1:0]    prod2_reg [0:2];
    logic signed [btt_pkg::COORD_W-1:0]  res_reg [0:2];
    btt_pkg::out_item_t                  out_reg;
    logic                                ov_reg;

    logic signed [btt_pkg::COORD_W-1:0]  ctl [0:3][0:2];
    logic signed [btt_pkg::SUM_W-1:0]    mid [0:2];
    logic signed [btt_pkg::ACC_W-1:0]    num [0:2];
    logic signed [btt_pkg::COORD_W-1:0]  bz [0:2];
    logic [2:0]                          div_done;
    logic                                div_start;
    logic [btt_pkg::DD_W-1:0]            a_val;
    logic [btt_pkg::D3_W-1:0]            p_a2b, p_ab2;
    logic [btt_pkg::TENSION_W-1:0]       omt;
    logic                                last;
    logic                                load;

    // Control points as a grid of point by coordinate.
    assign ctl[0][0] = job_reg.pts.p0_x;
    assign ctl[0][1] = job_reg.pts.p0_y;
    assign ctl[0][2] = job_reg.pts.p0_z;
    assign ctl[1][0] = job_reg.pts.p1_x;
    assign ctl[1][1] = job_reg.pts.p1_y;
    assign ctl[1][2] = job_reg.pts.p1_z;
    assign ctl[2][0] = job_reg.pts.p2_x;
    assign ctl[2][1] = job_reg.pts.p2_y;
    assign ctl[2][2] = job_reg.pts.p2_z;
    assign ctl[3][0] = job_reg.pts.p3_x;
    assign ctl[3][1] = job_reg.pts.p3_y;
    assign ctl[3][2] = job_reg.pts.p3_z;

    assign a_val = job_reg.dd - i_reg;
    assign p_a2b = btt_pkg::D3_W'(ab_reg) * btt_pkg::D3_W'(a_val);
    assign p_ab2 = btt_pkg::D3_W'(ab_reg) * btt_pkg::D3_W'(i_reg);
    assign omt   = btt_pkg::TENSION_ONE - job_reg.tension;
    assign last  = ({1'b0, i_reg} == (job_reg.n - btt_pkg::MAXP_W'(1)));
    assign load  = (state_reg == btt_pkg::B_PUT) && (!ov_reg || points.ready);

    // One divider per coordinate, all started together.
    for (genvar c = 0; c < 3; c++)
    begin : g_coord
        assign mid[c] = btt_pkg::SUM_W'(ctl[1][c]) + btt_pkg::SUM_W'(ctl[2][c]);
        assign num[c] = acc_reg[c]
                      + $signed({1'b0, (btt_pkg::ACC_W-1)'(job_reg.d3 >> 1)});

        btt_div u_div
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (num[c]),
            .den   (job_reg.d3),
            .done  (div_done[c]),
            .quo   (bz[c])
        );
    end

    // Point sequencer.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            btt_pkg::B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    state_next = btt_pkg::B_SQUARE;
                end
            end
            btt_pkg::B_SQUARE: state_next = btt_pkg::B_WEIGHT;
            btt_pkg::B_WEIGHT: state_next = btt_pkg::B_MAC;
            btt_pkg::B_MAC:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = btt_pkg::B_DIVGO;
                end
            end
            btt_pkg::B_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = btt_pkg::B_DIVWAIT;
            end
            btt_pkg::B_DIVWAIT:
            begin
                if (div_done[0])
                begin
                    state_next = btt_pkg::B_BLEND;
                end
            end
            btt_pkg::B_BLEND: state_next = btt_pkg::B_ROUND;
            btt_pkg::B_ROUND: state_next = btt_pkg::B_PUT;
            btt_pkg::B_PUT:
            begin
                if (load)
                begin
                    state_next = last ? btt_pkg::B_IDLE : btt_pkg::B_SQUARE;
                end
            end
            default: state_next = btt_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btt_pkg::B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (points.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Datapath of one point: weights, weighted sums, divide, blend, saturate.
    always_ff @(posedge clk)
    begin
        logic signed [btt_pkg::ACC_W-1:0] v;
        logic signed [btt_pkg::ACC_W-1:0] r;
        case (state_reg)
            btt_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    job_reg <= head;
                    i_reg   <= '0;
                end
            end
            btt_pkg::B_SQUARE:
            begin
                a2_reg <= btt_pkg::SQ_W'(a_val) * btt_pkg::SQ_W'(a_val);
                b2_reg <= btt_pkg::SQ_W'(i_reg) * btt_pkg::SQ_W'(i_reg);
                ab_reg <= btt_pkg::SQ_W'(a_val) * btt_pkg::SQ_W'(i_reg);
            end
            btt_pkg::B_WEIGHT:
            begin
                w_reg[0] <= btt_pkg::WGT_W'(btt_pkg::D3_W'(a2_reg) * btt_pkg::D3_W'(a_val));
                w_reg[1] <= btt_pkg::WGT_W'(p_a2b) + (btt_pkg::WGT_W'(p_a2b) << 1);
                w_reg[2] <= btt_pkg::WGT_W'(p_ab2) + (btt_pkg::WGT_W'(p_ab2) << 1);
                w_reg[3] <= btt_pkg::WGT_W'(btt_pkg::D3_W'(b2_reg) * btt_pkg::D3_W'(i_reg));
                k_reg    <= 2'd0;
                for (int c = 0; c < 3; c++)
                begin
                    acc_reg[c] <= '0;
                end
            end
            btt_pkg::B_MAC:
            begin
                k_reg <= k_reg + 2'd1;
                for (int c = 0; c < 3; c++)
                begin
                    acc_reg[c] <= acc_reg[c]
                                + btt_pkg::ACC_W'($signed({1'b0, w_reg[k_reg]}) * ctl[k_reg][c]);
                end
            end
            btt_pkg::B_BLEND:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod1_reg[c] <= btt_pkg::ACC_W'($signed({1'b0, omt}) * bz[c]);
                    prod2_reg[c] <= btt_pkg::ACC_W'($signed({1'b0, job_reg.tension}) * mid[c]);
                end
            end
            btt_pkg::B_ROUND:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v = (prod1_reg[c] <<< 1) + prod2_reg[c] + btt_pkg::BLD_ROUND;
                    r = v >>> btt_pkg::BLD_SHIFT;
                    if (r > btt_pkg::SAT_HI)
                    begin
                        res_reg[c] <= btt_pkg::COORD_W'(btt_pkg::SAT_HI);
                    end
                    else if (r < btt_pkg::SAT_LO)
                    begin
                        res_reg[c] <= btt_pkg::COORD_W'(btt_pkg::SAT_LO);
                    end
                    else
                    begin
                        res_reg[c] <= btt_pkg::COORD_W'(r);
                    end
                end
            end
            btt_pkg::B_PUT:
            begin
                if (load)
                begin
                    out_reg.point_index <= i_reg;
                    out_reg.out_x       <= res_reg[0];
                    out_reg.out_y       <= res_reg[1];
                    out_reg.out_z       <= res_reg[2];
                    out_reg.last_point  <= last;
                    i_reg               <= i_reg + btt_pkg::IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign points.valid = ov_reg;
    assign points.data  = out_reg;

endmodule

[rtl/bezier_tension_tessellator.sv]
`timescale 1ns / 1ps
// Channel   Role   Word
// items     sink   four control points, signed Q16.16
// cfg       sink   register index and write data
// points    source one curve point with index and last flag
//
// Most of a point's time is spent in the divider, which retires four quotient
// bits a cycle over a 52-bit weighted sum. The front end takes the next item
// and classifies it while the back end works, holding up to two items queued.
// Reset clears all control state and loads the register reset values.
// A stalled output holds its word while the next point is computed.
module bezier_tension_tessellator
(
    input  logic        clk,
    input  logic        rst_n,
    btt_in_if.sink      items,
    btt_cfg_if.sink     cfg,
    btt_out_if.source   points
);

    logic               push;
    logic               pop;
    btt_pkg::job_t      push_job;
    btt_pkg::job_t      head;
    btt_pkg::q_stat_t   qstat;

    btt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    btt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    btt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .points   (points)
    );

endmodule

[rtl/btt_checker.sv]
`timescale 1ns / 1ps
`include "bezier_tension_tessellator_assert.svh"

module btt_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  btt_pkg::out_item_t  out_data
);

    // No point is offered while reset is held.
    `BTT_ASSERT_ALWAYS(a_no_valid_in_reset, clk, !rst_n |-> !out_valid, "point valid in reset")

    // A stalled point keeps its word.
    `BTT_ASSERT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled point changed")

    // The highest index can only be the final point of a run.
    `BTT_ASSERT(a_top_index_last, clk, rst_n, out_valid && out_data.point_index == btt_pkg::IDX_W'(btt_pkg::MAX_POINTS - 1) |-> out_data.last_point, "top index not last")

endmodule

bind bezier_tension_tessellator btt_checker u_btt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .out_data  (points.data)
);

[sim/bezier_tension_tessellator_test.sv]
`timescale 1ns / 1ps

module bezier_tension_tessellator_test;
    import btt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD = 600;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
        in_item_t              item;
        bit                    has_typed;
        out_item_t             typed_first;
    } stim_row_t;

    logic clk;
    logic rst_n;

    btt_in_if  items();
    btt_cfg_if cfg();
    btt_out_if points();

    bezier_tension_tessellator dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .cfg    (cfg),
        .points (points)
    );

    // Shadow copy of the registers, updated as each write is accepted.
    logic [LEVEL_W-1:0]   sh_level;
    logic [TENSION_W-1:0] sh_tension;
    logic [MAXP_W-1:0]    sh_max;

    out_item_t pending_points[$];
    stim_row_t stim_rows[$];
    int  errors;
    int  items_sent;
    int  points_seen;
    int  cfg_writes;
    bit  no_gaps;
    bit  hold_req;
    bit  hold_done;
    int  hold_cnt;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #200ms;
        $display("bezier_tension_tessellator test failed");
        $finish;
    end

    // Round-toward-minus-infinity division.
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // One coordinate of a tensioned curve point.
    function automatic logic [COORD_W-1:0] curve_coord(longint q0, longint q1, longint q2,
                                                       longint q3, longint a, longint b,
                                                       longint d3, longint t);
        longint s;
        longint bz;
        longint v;
        longint r;
        s = a * a * a * q0 + 3 * a * a * b * q1 + 3 * a * b * b * q2 + b * b * b * q3;
        bz = floor_quot(s + d3 / 2, d3);
        v = 2 * (65536 - t) * bz + t * (q1 + q2);
        r = floor_quot(v + 65536, 131072);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[COORD_W-1:0];
    endfunction

    // Queue the curve points that one accepted item must produce.
    task automatic predict_points(input in_item_t it);
        int n;
        longint dd;
        longint d3;
        longint a;
        longint b;
        longint t;
        out_item_t o;
        n = 1 << sh_level;
        if (n > sh_max)
            n = sh_max;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        dd = (n > 1) ? n - 1 : 1;
        d3 = dd * dd * dd;
        t = sh_tension;
        for (int i = 0; i < n; i++)
        begin
            b = (n > 1) ? i : 0;
            a = dd - b;
            o.point_index = i[IDX_W-1:0];
            o.out_x = curve_coord(it.p0_x, it.p1_x, it.p2_x, it.p3_x, a, b, d3, t);
            o.out_y = curve_coord(it.p0_y, it.p1_y, it.p2_y, it.p3_y, a, b, d3, t);
            o.out_z = curve_coord(it.p0_z, it.p1_z, it.p2_z, it.p3_z, a, b, d3, t);
            o.last_point = (i == n - 1);
            pending_points.push_back(o);
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item; valid stays high when the next item follows at once.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.data  <= it;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        predict_points(it);
        items_sent++;
    endtask

    // Let the block go idle: every expected point out, then a margin.
    task automatic drain();
        items.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, done only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_LEVEL:
            begin
                if (val[LEVEL_W-1:0] < LEVEL_MIN)
                    sh_level = LEVEL_MIN;
                else if (val[LEVEL_W-1:0] > LEVEL_MAX)
                    sh_level = LEVEL_MAX;
                else
                    sh_level = val[LEVEL_W-1:0];
            end
            REG_TENSION:
                sh_tension = (val > TENSION_ONE) ? TENSION_HALF : val;
            REG_MAX:
                sh_max = val[MAXP_W-1:0];
            default:
                ;
        endcase
    endtask

    // Control point k at v_k; y is its complement and z is half of v_k.
    function automatic in_item_t mk_pts(logic [31:0] v0, logic [31:0] v1,
                                        logic [31:0] v2, logic [31:0] v3);
        in_item_t it;
        it.p0_x = v0; it.p0_y = ~v0; it.p0_z = $signed(v0) >>> 1;
        it.p1_x = v1; it.p1_y = ~v1; it.p1_z = $signed(v1) >>> 1;
        it.p2_x = v2; it.p2_y = ~v2; it.p2_z = $signed(v2) >>> 1;
        it.p3_x = v3; it.p3_y = ~v3; it.p3_z = $signed(v3) >>> 1;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
        if (r < 4)
            return 32'($signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000);
        return $urandom;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        logic [COORD_W-1:0] c[12];
        foreach (c[k])
            c[k] = rand_coord();
        it = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
        return it;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.index = idx;
        r.wdata = val;
        r.item = '0;
        r.has_typed = 1'b0;
        r.typed_first = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_item(in_item_t it, bit typed, out_item_t first);
        stim_row_t r;
        r.kind = ROW_ITEM;
        r.index = '0;
        r.wdata = '0;
        r.item = it;
        r.has_typed = typed;
        r.typed_first = first;
        stim_rows.push_back(r);
    endfunction

    // Output side: check each accepted point, then pick the next ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points.ready <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (points.valid && points.ready)
            begin
                points_seen++;
                if (pending_points.size() == 0)
                begin
                    $display("%0t: unexpected point %p", $time, points.data);
                    errors++;
                end
                else if (points.data !== pending_points[0])
                begin
                    $display("%0t: point mismatch, expected %p, actual %p",
                             $time, pending_points[0], points.data);
                    errors++;
                    void'(pending_points.pop_front());
                end
                else
                begin
                    void'(pending_points.pop_front());
                end
            end
            if (hold_cnt > 0)
            begin
                points.ready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (hold_req && !hold_done)
            begin
                points.ready <= 1'b0;
                hold_cnt <= LONG_HOLD;
                hold_done <= 1'b1;
            end
            else
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    points.ready <= 1'b0;
                    hold_cnt <= $urandom_range(10, 50);
                end
                else
                    points.ready <= (no_gaps || r >= 25);
            end
        end
    end

    initial
    begin
        out_item_t first;
        in_item_t it;
        int phase_items;
        errors = 0;
        items_sent = 0;
        points_seen = 0;
        cfg_writes = 0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        sh_level = LEVEL_MIN;
        sh_tension = TENSION_HALF;
        sh_max = MAXP_CAP;
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.data = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_LEVEL;
        cfg.wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With zero tension the first point is P0 itself.
        add_item(mk_pts(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0004_0000),
                 1'b0, '0);
        add_cfg(REG_TENSION, 17'd0);
        first = '{6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h3fff_ffff, 1'b0};
        add_item(mk_pts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff),
                 1'b1, first);
        add_cfg(REG_LEVEL, 17'd0);
        first = '{6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hc000_0000, 1'b0};
        add_item(mk_pts(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff),
                 1'b1, first);
        add_cfg(REG_LEVEL, 17'h1fff);
        add_item(mk_pts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                 1'b0, '0);
        add_cfg(REG_TENSION, 17'd65536);
        add_item(mk_pts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000),
                 1'b0, '0);
        add_cfg(REG_TENSION, 17'h1ffff);
        add_cfg(REG_MAX, 17'd0);
        add_item(mk_pts(32'h1234_5678, 32'h0, 32'h0, 32'h0), 1'b0, '0);
        add_cfg(REG_MAX, 17'd1);
        add_cfg(REG_TENSION, 17'd0);
        first = '{6'd0, 32'h0003_0000, 32'hfffc_ffff, 32'h0001_8000, 1'b1};
        add_item(mk_pts(32'h0003_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0), 1'b1, first);
        add_cfg(REG_MAX, 17'h1ff);
        add_cfg(REG_UNUSED, 17'd5);
        add_cfg(REG_LEVEL, 17'd3);
        add_item(mk_pts(32'hffff_0000, 32'h0000_8000, 32'h0001_0000, 32'hfff0_0000),
                 1'b0, '0);
        add_cfg(REG_MAX, 17'd5);
        add_cfg(REG_TENSION, 17'd12345);
        add_item(rand_item(), 1'b0, '0);

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_CFG)
                write_reg(stim_rows[k].index, stim_rows[k].wdata);
            else
            begin
                int before_cnt;
                before_cnt = pending_points.size();
                send_item(stim_rows[k].item);
                if (stim_rows[k].has_typed &&
                    pending_points[before_cnt] !== stim_rows[k].typed_first)
                begin
                    $display("%0t: first point of row %0d, expected %p, actual %p", $time,
                             k, stim_rows[k].typed_first, pending_points[before_cnt]);
                    errors++;
                end
            end
        end

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < 16; ph++)
        begin
            int r;
            r = $urandom_range(0, 9);
            write_reg(REG_LEVEL, (ph == 5) ? 17'd6 :
                      17'({14'($urandom_range(0, 16383)),
                           3'(r < 7 ? $urandom_range(0, 3) : $urandom_range(4, 7))}));
            r = $urandom_range(0, 5);
            write_reg(REG_TENSION, (r == 0) ? 17'd0 : (r == 1) ? TENSION_ONE
                                                     : 17'($urandom));
            r = $urandom_range(0, 7);
            write_reg(REG_MAX, (r == 0) ? 17'd0 : (r == 1) ? 17'd1 :
                      (r == 2) ? 17'd127 : 17'($urandom_range(2, 64)));
            if (ph == 3)
            begin
                write_reg(REG_LEVEL, 17'd3);
                write_reg(REG_MAX, 17'd64);
                no_gaps = 1'b1;
                hold_req = 1'b1;
            end
            phase_items = (ph == 5) ? 4 : 20;
            for (int j = 0; j < phase_items; j++)
            begin
                it = rand_item();
                send_item(it);
            end
            no_gaps = 1'b0;
        end

        drain();
        $display("Sent %0d items and %0d register writes; %0d curve points checked.",
                 items_sent, cfg_writes, points_seen);
        if (errors == 0)
            $display("bezier_tension_tessellator test passed");
        else
            $display("bezier_tension_tessellator test failed");
        $finish;
    end

endmodule

[bezier_tension_tessellator.f]
+incdir+rtl
rtl/btt_pkg.sv
rtl/btt_if.sv
rtl/btt_front.sv
rtl/btt_queue.sv
rtl/btt_div.sv
rtl/btt_back.sv
rtl/bezier_tension_tessellator.sv
rtl/btt_checker.sv
sim/bezier_tension_tessellator_test.sv
